// ===== hdl/affine_transform_apply_defines.svh =====
// ----------------------------------------------------------------------------
// affine transform apply - assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_APPLY_DEFINES_SVH
`define AFFINE_TRANSFORM_APPLY_DEFINES_SVH
`ifndef SYNTHESIS
`define ATF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATF_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATF_ASSERT_RST(label, clk, rst_n, prop, msg)
`define ATF_ASSERT_ALL(label, clk, prop, msg)
`endif
`endif

// ===== hdl/atf_pkg.sv =====
// ----------------------------------------------------------------------------
// atf_pkg
// shared types, widths and helpers of the affine transform unit
// ----------------------------------------------------------------------------
package atf_pkg;

    localparam int CW  = 32;        // coordinate width, q16.16
    localparam int EW  = 16;        // matrix entry width
    localparam int PW  = CW + EW;   // product width
    localparam int SW  = 51;        // q.28 sum width
    localparam int RW  = SW + 1;    // divider remainder width
    localparam int NW  = SW + 17;   // scaled numerator width
    localparam int QW  = 32;        // quotient bits
    localparam int DIV_LAT  = QW + 1;
    localparam int LANE_LAT = 2;
    localparam int PIPE_LAT = LANE_LAT + DIV_LAT + 1;

    localparam logic [CW-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [CW-1:0] SAT_MIN = 32'h8000_0000;
    localparam logic signed [SW-1:0] W_ONE = SW'(64'sd268435456);

    typedef enum logic [1:0] {
        KIND_POINT  = 2'd0,
        KIND_VECTOR = 2'd1,
        KIND_NORMAL = 2'd2,
        KIND_BOX    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_FWD_ROW0 = 3'd0,
        REG_FWD_ROW1 = 3'd1,
        REG_FWD_ROW2 = 3'd2,
        REG_FWD_ROW3 = 3'd3,
        REG_INV_ROW0 = 3'd4,
        REG_INV_ROW1 = 3'd5,
        REG_INV_ROW2 = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_kind              kind;
        logic               wz;
        logic               w1;
        logic [2:0]         pos;
        logic [2:0]         neg;
        logic [5:0][CW-1:0] rnd;
    } t_side;

    // nearest, ties up, then clamp to 32 bits
    function automatic logic [CW-1:0] round_q28(input logic signed [SW-1:0] x);
        logic signed [SW:0] y;
        logic [SW-12:0]     sh;
        begin
            y  = {x[SW-1], x} + (SW+1)'(2048);
            sh = y[SW:12];
            if (sh[SW-12:CW-1] == '0 || sh[SW-12:CW-1] == '1) begin
                round_q28 = sh[CW-1:0];
            end else if (sh[SW-12]) begin
                round_q28 = SAT_MIN;
            end else begin
                round_q28 = SAT_MAX;
            end
        end
    endfunction

endpackage

// ===== hdl/atf_lane.sv =====
// ----------------------------------------------------------------------------
// atf_lane
// one matrix row: three products per corner, sums, min/max for boxes, point and box translation
// ----------------------------------------------------------------------------
module atf_lane (
    input  logic                          i_clk,
    input  atf_pkg::t_kind                i_kind,
    input  logic signed [atf_pkg::CW-1:0] i_a [3],
    input  logic signed [atf_pkg::CW-1:0] i_b [3],
    input  logic signed [atf_pkg::EW-1:0] i_m [3],
    input  logic signed [atf_pkg::EW-1:0] i_t,
    output logic signed [atf_pkg::SW-1:0] o_s,
    output logic signed [atf_pkg::SW-1:0] o_smax
);
    import atf_pkg::*;

    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    t_kind                r_kind;
    logic signed [EW-1:0] r_t;
    logic signed [SW-1:0] r_s, r_smax;
    logic signed [SW-1:0] n_s, n_smax;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_pa[j] <= i_a[j] * i_m[j];
            r_pb[j] <= i_b[j] * i_m[j];
        end
        r_kind <= i_kind;
        r_t    <= i_t;
    end

    always_comb begin
        logic signed [SW-1:0] va, vb, tt;
        n_s    = '0;
        n_smax = '0;
        for (int j = 0; j < 3; j++) begin
            va = SW'(r_pa[j]);
            vb = SW'(r_pb[j]);
            if (r_kind == KIND_BOX) begin
                n_s    = n_s + ((va < vb) ? va : vb);
                n_smax = n_smax + ((va < vb) ? vb : va);
            end else begin
                n_s = n_s + va;
            end
        end
        tt = {{(SW-EW-24){r_t[EW-1]}}, r_t, 24'b0};
        if (r_kind == KIND_POINT || r_kind == KIND_BOX) begin
            n_s    = n_s + tt;
            n_smax = n_smax + tt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_smax <= n_smax;
    end

    assign o_s    = r_s;
    assign o_smax = r_smax;

endmodule

// ===== hdl/atf_div.sv =====
// ----------------------------------------------------------------------------
// atf_div
// pipelined restoring divider, one quotient bit per stage, rounded and clamped
// ----------------------------------------------------------------------------
module atf_div (
    input  logic                          i_clk,
    input  logic signed [atf_pkg::SW-1:0] i_s,
    input  logic signed [atf_pkg::SW-1:0] i_w,
    output logic        [atf_pkg::CW-1:0] o_q
);
    import atf_pkg::*;

    logic [RW-1:0] r_rem [QW+1];
    logic [SW-1:0] r_aw  [QW+1];
    logic [QW-1:0] r_nlo [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];

    // setup: magnitudes, scaled numerator with half divisor, overflow test
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] an, aw;
        logic [NW-1:0] num;
        an = i_s[SW-1] ? SW'(-i_s) : SW'(i_s);
        aw = i_w[SW-1] ? SW'(-i_w) : SW'(i_w);
        num = {1'b0, an, 16'b0} + NW'(aw >> 1);
        r_rem[0] <= RW'(num[NW-1:QW]);
        r_aw[0]  <= aw;
        r_nlo[0] <= num[QW-1:0];
        r_q[0]   <= '0;
        r_neg[0] <= i_s[SW-1] ^ i_w[SW-1];
        r_ovf[0] <= (RW'(num[NW-1:QW]) >= RW'(aw));
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [RW-1:0] rr;
        assign rr = {r_rem[k-1][RW-2:0], r_nlo[k-1][QW-1]};
        always_ff @(posedge i_clk) begin
            if (rr >= RW'(r_aw[k-1])) begin
                r_rem[k] <= rr - RW'(r_aw[k-1]);
                r_q[k]   <= {r_q[k-1][QW-2:0], 1'b1};
            end else begin
                r_rem[k] <= rr;
                r_q[k]   <= {r_q[k-1][QW-2:0], 1'b0};
            end
            r_aw[k]  <= r_aw[k-1];
            r_nlo[k] <= {r_nlo[k-1][QW-2:0], 1'b0};
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    always_comb begin
        if (r_ovf[QW] || r_q[QW][QW-1]) begin
            o_q = r_neg[QW] ? SAT_MIN : SAT_MAX;
        end else if (r_neg[QW]) begin
            o_q = -r_q[QW];
        end else begin
            o_q = r_q[QW];
        end
    end

endmodule

// ===== hdl/affine_transform_apply.sv =====
// ----------------------------------------------------------------------------
// affine_transform_apply
// 4x4 homogeneous transform of points, vectors, normals and boxes
// ----------------------------------------------------------------------------
// o_valid follows the accepting edge through the lane products, the lane sums,
// the divider setup, the divider stages and the merge register
// throughput: one beat per cycle, o_busy never rises
// the 32-stage point divider is the long pole, every kind walks the same pipe
// reset: synchronous active low, clears valid pipe and loads identity matrices
// results are strobed once on o_valid, the receiver cannot stall
module affine_transform_apply (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_kind,
    input  logic signed [atf_pkg::CW-1:0] i_in_x,
    input  logic signed [atf_pkg::CW-1:0] i_in_y,
    input  logic signed [atf_pkg::CW-1:0] i_in_z,
    input  logic signed [atf_pkg::CW-1:0] i_in_max_x,
    input  logic signed [atf_pkg::CW-1:0] i_in_max_y,
    input  logic signed [atf_pkg::CW-1:0] i_in_max_z,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [63:0]                   i_cfg_wdata,
    output logic                          o_valid,
    output logic signed [atf_pkg::CW-1:0] o_out_x,
    output logic signed [atf_pkg::CW-1:0] o_out_y,
    output logic signed [atf_pkg::CW-1:0] o_out_z,
    output logic signed [atf_pkg::CW-1:0] o_out_max_x,
    output logic signed [atf_pkg::CW-1:0] o_out_max_y,
    output logic signed [atf_pkg::CW-1:0] o_out_max_z,
    output logic                          o_w_zero
);
    import atf_pkg::*;

`include "affine_transform_apply_defines.svh"

    // matrix registers, identity after reset
    logic [63:0] r_fwd [4];
    logic [47:0] r_inv [3];

    logic                r_vld [PIPE_LAT];
    logic                acc;
    t_kind               kind_in;
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [SW-1:0] s [4];
    logic signed [SW-1:0] smax [4];
    logic [CW-1:0]       q [3];
    t_side               n_side;
    t_side               r_side [DIV_LAT];
    logic                r_out_box;
    logic [CW-1:0]       r_out [6];
    logic                r_out_wz;

    assign o_busy  = 1'b0;
    assign acc     = i_start && !o_busy;
    assign kind_in = t_kind'(i_kind);
    assign a[0] = i_in_x;
    assign a[1] = i_in_y;
    assign a[2] = i_in_z;
    assign b[0] = i_in_max_x;
    assign b[1] = i_in_max_y;
    assign b[2] = i_in_max_z;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd[0] <= 64'h0000_0000_0000_1000;
            r_fwd[1] <= 64'h0000_0000_1000_0000;
            r_fwd[2] <= 64'h0000_1000_0000_0000;
            r_fwd[3] <= 64'h0010_0000_0000_0000;
            r_inv[0] <= 48'h0000_0000_1000;
            r_inv[1] <= 48'h0000_1000_0000;
            r_inv[2] <= 48'h1000_0000_0000;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FWD_ROW0: r_fwd[0] <= i_cfg_wdata;
                REG_FWD_ROW1: r_fwd[1] <= i_cfg_wdata;
                REG_FWD_ROW2: r_fwd[2] <= i_cfg_wdata;
                REG_FWD_ROW3: r_fwd[3] <= i_cfg_wdata;
                REG_INV_ROW0: r_inv[0] <= i_cfg_wdata[47:0];
                REG_INV_ROW1: r_inv[1] <= i_cfg_wdata[47:0];
                REG_INV_ROW2: r_inv[2] <= i_cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // one lane per matrix row, row 3 is the w lane
    for (genvar i = 0; i < 4; i++) begin : g_lane
        logic signed [EW-1:0] m [3];
        for (genvar j = 0; j < 3; j++) begin : g_col
            if (i < 3) begin : g_sel
                // normals use the transposed inverse
                assign m[j] = (kind_in == KIND_NORMAL) ? r_inv[j][EW*i +: EW]
                                                       : r_fwd[i][EW*j +: EW];
            end else begin : g_w
                assign m[j] = r_fwd[i][EW*j +: EW];
            end
        end
        atf_lane u_lane (
            .i_clk  (i_clk),
            .i_kind (kind_in),
            .i_a    (a),
            .i_b    (b),
            .i_m    (m),
            .i_t    (r_fwd[i][EW*3 +: EW]),
            .o_s    (s[i]),
            .o_smax (smax[i])
        );
    end

    // kind trails the lanes by their two stages
    t_kind r_kind1, r_kind2;
    always_ff @(posedge i_clk) begin
        r_kind1 <= kind_in;
        r_kind2 <= r_kind1;
    end

    // per-row divide by w for points
    for (genvar i = 0; i < 3; i++) begin : g_div
        atf_div u_div (
            .i_clk (i_clk),
            .i_s   (s[i]),
            .i_w   (s[3]),
            .o_q   (q[i])
        );
    end

    // side data that skips the divider: rounded sums, w flags, signs
    always_comb begin
        n_side.kind = r_kind2;
        n_side.wz   = (s[3] == '0);
        n_side.w1   = (s[3] == W_ONE);
        for (int i = 0; i < 3; i++) begin
            n_side.pos[i]   = !s[i][SW-1] && (s[i] != '0);
            n_side.neg[i]   = s[i][SW-1];
            n_side.rnd[i]   = round_q28(s[i]);
            n_side.rnd[3+i] = round_q28(smax[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= acc;
            for (int k = 1; k < PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // merge: pick divider, rounded or saturated value per kind
    always_ff @(posedge i_clk) begin
        t_side sd;
        sd = r_side[DIV_LAT-1];
        r_out_box <= (sd.kind == KIND_BOX);
        r_out_wz  <= (sd.kind == KIND_POINT) && sd.wz;
        for (int i = 0; i < 3; i++) begin
            if (sd.kind == KIND_POINT) begin
                if (sd.wz) begin
                    r_out[i] <= sd.pos[i] ? SAT_MAX : (sd.neg[i] ? SAT_MIN : '0);
                end else if (sd.w1) begin
                    r_out[i] <= sd.rnd[i];
                end else begin
                    r_out[i] <= q[i];
                end
            end else begin
                r_out[i] <= sd.rnd[i];
            end
            r_out[3+i] <= (sd.kind == KIND_BOX) ? sd.rnd[3+i] : '0;
        end
    end

    assign o_valid     = r_vld[PIPE_LAT-1];
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_max_x = r_out[3];
    assign o_out_max_y = r_out[4];
    assign o_out_max_z = r_out[5];
    assign o_w_zero    = r_out_wz;

    `ATF_ASSERT_ALL(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "beat out right after reset")
    `ATF_ASSERT_RST(a_latency, i_clk, i_rst_n, o_valid |-> $past(acc, 36), "beat without start")
    `ATF_ASSERT_RST(a_max_zero, i_clk, i_rst_n,
        o_valid && !r_out_box |-> (o_out_max_x == '0 && o_out_max_y == '0 && o_out_max_z == '0),
        "box max fields set on non-box beat")
    `ATF_ASSERT_RST(a_wz_sat, i_clk, i_rst_n,
        o_valid && o_w_zero |-> (o_out_x == SAT_MAX || o_out_x == SAT_MIN || o_out_x == '0),
        "zero w without saturated x")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - affine transform apply testbench
// drives points, vectors, normals and boxes through the transform unit under
// a series of matrix settings and checks every result against a bit-exact
// software predictor held in a small scoreboard class
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atf_pkg::*;

    localparam int LATENCY  = 36;     // accepting edge to the edge taking the result
    localparam int SETTLE   = LATENCY + 8;
    localparam int WATCHDOG = 2000;   // cycles with no beat on either side
    localparam int PHASES   = 9;
    localparam int PER_PHASE = 190;

    // one input beat
    typedef struct {
        t_kind kind;
        int    lo[3];   // coordinate or box minimum
        int    hi[3];   // box maximum
    } t_item;

    // one result beat
    typedef struct {
        int lo[3];
        int hi[3];
        bit wz;
    } t_coords;

    // ------------------------------------------------------------------------
    // scoreboard: matrix copy, transform predictor and queue of expectations
    // ------------------------------------------------------------------------
    class transform_scoreboard;
        bit [63:0] fwd[4];
        bit [47:0] inv[3];
        t_coords   pending[$];
        int        errors;

        function void load_identity();
            fwd[0] = 64'h1000;
            fwd[1] = 64'h1000 << 16;
            fwd[2] = 64'h1000 << 32;
            fwd[3] = 64'h0010 << 48;
            inv[0] = 48'h1000;
            inv[1] = 48'h1000 << 16;
            inv[2] = 48'h1000 << 32;
        endfunction

        function void set_reg(t_reg_idx idx, bit [63:0] val);
            if (idx <= REG_FWD_ROW3) begin
                fwd[idx] = val;
            end else begin
                inv[idx - REG_INV_ROW0] = val[47:0];
            end
        endfunction

        function longint coef(bit [63:0] row, int col);
            logic signed [15:0] e;
            e = row[col*16 +: 16];
            return longint'(e);
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7fff_ffff;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return int'(v);
        endfunction

        // q.28 to q16.16, nearest with ties up
        function int round_q28_to_q16(longint x);
            return clamp32((x + 2048) >>> 12);
        endfunction

        // sum * 2^16 / w, magnitudes rounded half away from zero
        function int divide_by_w(longint num, longint w);
            longint unsigned an, aw, q;
            an = (num < 0) ? -num : num;
            aw = (w < 0) ? -w : w;
            q  = ((an << 16) + aw / 2) / aw;
            if ((num < 0) != (w < 0)) begin
                if (q > 64'h8000_0000) return 32'h8000_0000;
                return int'(-q);
            end
            return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : int'(q);
        endfunction

        function t_coords transform(t_item it);
            t_coords r;
            longint  s[4];
            longint  smax[3];
            longint  m, v1, v2, t, w;
            for (int i = 0; i < 3; i++) begin
                r.lo[i] = 0;
                r.hi[i] = 0;
            end
            r.wz = 1'b0;
            for (int i = 0; i < 4; i++) begin
                s[i] = 0;
                if (i < 3) smax[i] = 0;
                for (int j = 0; j < 3; j++) begin
                    if (it.kind == KIND_NORMAL) begin
                        if (i < 3) s[i] += coef(inv[j], i) * longint'(it.lo[j]);
                    end else if (it.kind == KIND_BOX) begin
                        if (i < 3) begin
                            m  = coef(fwd[i], j);
                            v1 = longint'(it.lo[j]) * m;
                            v2 = longint'(it.hi[j]) * m;
                            s[i]    += (v1 < v2) ? v1 : v2;
                            smax[i] += (v1 < v2) ? v2 : v1;
                        end
                    end else begin
                        s[i] += coef(fwd[i], j) * longint'(it.lo[j]);
                    end
                end
                if (it.kind == KIND_POINT || (it.kind == KIND_BOX && i < 3)) begin
                    t = coef(fwd[i], 3) <<< 24;
                    s[i] += t;
                    if (i < 3) smax[i] += t;
                end
            end
            if (it.kind == KIND_POINT) begin
                w = s[3];
                for (int i = 0; i < 3; i++) begin
                    if (w == 0) begin
                        r.lo[i] = (s[i] > 0) ? 32'h7fff_ffff :
                                  (s[i] < 0) ? 32'h8000_0000 : 0;
                    end else if (w == 64'sd268435456) begin
                        r.lo[i] = round_q28_to_q16(s[i]);
                    end else begin
                        r.lo[i] = divide_by_w(s[i], w);
                    end
                end
                r.wz = (w == 0);
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r.lo[i] = round_q28_to_q16(s[i]);
                    if (it.kind == KIND_BOX) r.hi[i] = round_q28_to_q16(smax[i]);
                end
            end
            return r;
        endfunction

        function void note_input(t_item it);
            pending.push_back(transform(it));
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %08h, expected %08h", what, got, want);
            errors++;
        endtask

        task check_result(t_coords got);
            t_coords want;
            if (pending.size() == 0) begin
                $display("mismatch: result beat with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.lo[i] !== want.lo[i]) report($sformatf("lo[%0d]", i), got.lo[i], want.lo[i]);
                if (got.hi[i] !== want.hi[i]) report($sformatf("hi[%0d]", i), got.hi[i], want.hi[i]);
            end
            if (got.wz !== want.wz) report("w_zero", int'(got.wz), int'(want.wz));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // block and its ports
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [1:0]        i_kind;
    logic signed [31:0] i_in_x, i_in_y, i_in_z;
    logic signed [31:0] i_in_max_x, i_in_max_y, i_in_max_z;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [63:0]       i_cfg_wdata;
    logic              o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic signed [31:0] o_out_max_x, o_out_max_y, o_out_max_z;
    logic              o_w_zero;

    affine_transform_apply dut (.*);

    transform_scoreboard sb = new();
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input beats go to the predictor, result beats to the checker
    always @(posedge i_clk) begin
        t_item   it;
        t_coords got;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                it.kind = t_kind'(i_kind);
                it.lo = '{i_in_x, i_in_y, i_in_z};
                it.hi = '{i_in_max_x, i_in_max_y, i_in_max_z};
                sb.note_input(it);
            end
            if (o_valid) begin
                got.lo = '{o_out_x, o_out_y, o_out_z};
                got.hi = '{o_out_max_x, o_out_max_y, o_out_max_z};
                got.wz = o_w_zero;
                sb.check_result(got);
            end
        end
    end

    // watchdog: no beat on either side for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one beat, with a random idle gap ahead of it
    task send_item(t_item it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_kind     <= it.kind;
        i_in_x     <= it.lo[0];
        i_in_y     <= it.lo[1];
        i_in_z     <= it.lo[2];
        i_in_max_x <= it.hi[0];
        i_in_max_y <= it.hi[1];
        i_in_max_z <= it.hi[2];
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    // drain the pipe, then let the tail settle
    task wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write the whole register set back to back, only while idle
    task write_matrices(bit [63:0] vals[7]);
        for (int r = 0; r < 7; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= 3'(r);
            i_cfg_wdata <= vals[r];
            sb.set_reg(t_reg_idx'(r), vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function bit [15:0] pick_entry(int mode, int r, int c);
        case (mode)
            1: return 16'($urandom);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            5: return 16'h0000;
            6: return 16'hffff;
            default: begin
                // near identity with modest off-diagonal terms
                if (c == 3) return 16'($urandom_range(0, 8191)) - 16'd4096;
                return ((r == c) ? 16'h1000 : 16'h0) + 16'($urandom_range(0, 2047)) - 16'd1024;
            end
        endcase
    endfunction

    // modes: 0 near identity, 1 random, 2 extreme entries, 3 zero w row,
    // 4 forced unit w, 5 all zero, 6 all minus one lsb
    function void build_matrices(int mode, output bit [63:0] vals[7]);
        for (int r = 0; r < 7; r++) begin
            vals[r] = {$urandom, $urandom};   // inverse rows keep junk on top
            for (int c = 0; c < 4; c++) begin
                if (r < 4 || c < 3) vals[r][c*16 +: 16] = pick_entry(mode, r, c);
            end
        end
        if (mode == 3) begin
            vals[REG_FWD_ROW3] = '0;
            for (int r = 0; r < 3; r++) begin
                if ($urandom_range(0, 1)) vals[r][63:48] = '0;
            end
        end else if (mode == 4) begin
            vals[REG_FWD_ROW3] = 64'h0010 << 48;
        end else if (mode == 0) begin
            vals[REG_FWD_ROW3][47:0] = {16'($urandom_range(0, 31)) - 16'd16,
                                        16'($urandom_range(0, 31)) - 16'd16,
                                        16'($urandom_range(0, 31)) - 16'd16};
        end
    endfunction

    function int pick_coord();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 4) return int'($urandom);
        if (sel < 6) return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    function t_item random_item();
        t_item it;
        it.kind = t_kind'($urandom_range(0, 3));
        for (int i = 0; i < 3; i++) begin
            it.lo[i] = pick_coord();
            it.hi[i] = pick_coord();
        end
        // sprinkle all-zero coordinates so a zero w meets a zero sum
        if ($urandom_range(0, 19) == 0) it.lo = '{0, 0, 0};
        return it;
    endfunction

    function t_item make_item(t_kind k, int x, int y, int z, int mx, int my, int mz);
        t_item it;
        it.kind = k;
        it.lo   = '{x, y, z};
        it.hi   = '{mx, my, mz};
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit [63:0] vals[7];
        t_item     directed[$];
        int        modes[PHASES] = '{2, 3, 4, 1, 0, 5, 6, 1, 3};

        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_kind      = '0;
        i_in_x      = '0;
        i_in_y      = '0;
        i_in_z      = '0;
        i_in_max_x  = '0;
        i_in_max_y  = '0;
        i_in_max_z  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        sb.load_identity();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats on the reset identity: unit w path, every kind,
        // field extremes, inverted box
        directed.push_back(make_item(KIND_POINT, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_item(KIND_POINT, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 0, 0));
        directed.push_back(make_item(KIND_POINT, -1, 32'h0001_0000, 32'hffff_0000, 0, 0, 0));
        directed.push_back(make_item(KIND_VECTOR, 32'h7fff_ffff, 32'h8000_0000, -1, 5, 6, 7));
        directed.push_back(make_item(KIND_VECTOR, 0, 1, 32'h0003_8000, 0, 0, 0));
        directed.push_back(make_item(KIND_NORMAL, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
        directed.push_back(make_item(KIND_NORMAL, 1, -1, 32'h1234_5678, 0, 0, 0));
        directed.push_back(make_item(KIND_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        directed.push_back(make_item(KIND_BOX, 32'h0010_0000, 0, -5,
                                     32'hfff0_0000, -7, 32'h0001_0000));   // inverted box
        directed.push_back(make_item(KIND_BOX, 0, 0, 0, 0, 0, 0));
        foreach (directed[n]) send_item(directed[n]);
        wait_drained();

        // one phase per matrix setting, all registers rewritten each time
        for (int p = 0; p < PHASES; p++) begin
            build_matrices(modes[p], vals);
            write_matrices(vals);
            for (int n = 0; n < PER_PHASE; n++) send_item(random_item());
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
